// ===== rtl/core/mf3d_pkg.sv =====
// shared types and constants for the 3-d median filter
package mf3d_pkg;

  localparam int DimMax     = 32;
  localparam int PosBits    = 5;
  localparam int DimBits    = 6;
  localparam int WinBits    = 3;
  localparam int PixBits    = 16;
  localparam int AddrBits   = 3 * PosBits;
  localparam int WinCap     = 343;
  localparam int CntBits    = 9;
  localparam int QueueDepth = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register map indexes
  localparam logic [2:0] REG_DIM_X = 3'd0;
  localparam logic [2:0] REG_DIM_Y = 3'd1;
  localparam logic [2:0] REG_DIM_Z = 3'd2;
  localparam logic [2:0] REG_WIN_X = 3'd3;
  localparam logic [2:0] REG_WIN_Y = 3'd4;
  localparam logic [2:0] REG_WIN_Z = 3'd5;

  // one classified request as passed from front to back
  typedef struct packed {
    logic                 query;
    logic [PosBits-1:0]   cx;
    logic [PosBits-1:0]   cy;
    logic [PosBits-1:0]   cz;
    logic [PixBits-1:0]   value;
  } req_t;

  // effective geometry after saturation
  typedef struct packed {
    logic [DimBits-1:0] dx;
    logic [DimBits-1:0] dy;
    logic [DimBits-1:0] dz;
    logic [WinBits-1:0] wx;
    logic [WinBits-1:0] wy;
    logic [WinBits-1:0] wz;
  } geom_t;

  // reflect a window coordinate back into 0..d-1; i is signed
  function automatic logic [PosBits-1:0] mirror(input logic signed [7:0] i,
                                                 input logic [DimBits-1:0] d);
    logic signed [7:0] r;
    logic signed [7:0] ds;
    ds = $signed({2'b00, d});
    r = i;
    if (r < 0) r = -8'sd1 - r;
    else if (r >= ds) r = 8'(2 * ds - 8'sd1 - r);
    if (r < 0) r = 8'sd0;
    if (r >= ds) r = 8'(ds - 8'sd1);
    return r[PosBits-1:0];
  endfunction

endpackage

// ===== rtl/core/mf3d_front.sv =====
// front: accepts requests, clamps query coordinates, queues them for the back
module mf3d_front import mf3d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic [PosBits-1:0] pos_x,
  input  logic [PosBits-1:0] pos_y,
  input  logic [PosBits-1:0] pos_z,
  input  logic [PixBits-1:0] voxel_value,
  input  geom_t              geom,
  output logic               req_valid,
  output req_t               req,
  input  logic               req_take
);

  req_t       q [QueueDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  req_t       incoming;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    incoming.query = command;
    incoming.value = voxel_value;
    if (command == CMD_QUERY) begin
      incoming.cx = ({1'b0, pos_x} < geom.dx) ? pos_x : PosBits'(geom.dx - 6'd1);
      incoming.cy = ({1'b0, pos_y} < geom.dy) ? pos_y : PosBits'(geom.dy - 6'd1);
      incoming.cz = ({1'b0, pos_z} < geom.dz) ? pos_z : PosBits'(geom.dz - 6'd1);
    end else begin
      incoming.cx = pos_x;
      incoming.cy = pos_y;
      incoming.cz = pos_z;
    end
  end

  assign full      = (count == 2'(QueueDepth));
  assign req_valid = (count != 2'd0);
  assign req       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/core/mf3d_back.sv =====
// back: volume memory, window gather, rank selection and result register
module mf3d_back import mf3d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  req_t               req,
  output logic               req_take,
  input  geom_t              geom,
  output logic               empty,
  input  logic               pop,
  output logic [PixBits-1:0] median_value
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GATHER = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [PixBits-1:0] vol [DimMax*DimMax*DimMax];
  logic [PixBits-1:0] win [WinCap];

  logic [PosBits-1:0] cx, cy, cz;
  logic [WinBits-1:0] a, b, c;
  logic [CntBits-1:0] n;         // samples gathered
  logic [CntBits-1:0] wr_idx;
  logic               rd_pend;
  logic [PixBits-1:0] vol_q;

  // rank search: for each candidate i count less and equal across window
  logic [CntBits-1:0] cand;
  logic [CntBits-1:0] jdx;
  logic [PixBits-1:0] cand_val;
  logic [PixBits-1:0] win_q;
  logic [CntBits-1:0] less_cnt, eq_cnt;
  logic               scan_phase; // 0: load candidate, 1: compare sweep
  logic               cmp_pend;
  logic [CntBits-1:0] rank;

  logic               out_full;
  logic [PixBits-1:0] result;

  logic signed [7:0]  ix, iy, iz;
  logic [AddrBits-1:0] rd_addr;
  logic               last_elem;
  logic [CntBits-1:0] win_rd_addr;
  logic               start;

  assign ix = $signed({3'b000, cx}) - $signed({5'b0, geom.wx >> 1}) + $signed({5'b0, a});
  assign iy = $signed({3'b000, cy}) - $signed({5'b0, geom.wy >> 1}) + $signed({5'b0, b});
  assign iz = $signed({3'b000, cz}) - $signed({5'b0, geom.wz >> 1}) + $signed({5'b0, c});
  assign rd_addr = {mirror(ix, geom.dx), mirror(iy, geom.dy), mirror(iz, geom.dz)};
  assign last_elem = (a == geom.wx - 3'd1) && (b == geom.wy - 3'd1) && (c == geom.wz - 3'd1);

  assign start    = (state == S_IDLE) && req_valid && !out_full;
  assign req_take = start;
  assign rank     = n >> 1;
  assign win_rd_addr = scan_phase ? jdx : cand;

  // volume memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (start && req.query == CMD_WRITE) vol[{req.cx, req.cy, req.cz}] <= req.value;
    if (state == S_GATHER) vol_q <= vol[rd_addr];
  end

  // window scratch memory
  always_ff @(posedge clk) begin
    if (rd_pend) win[wr_idx] <= vol_q;
    win_q <= win[win_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      rd_pend  <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      if (out_full && pop) out_full <= 1'b0;
      rd_pend <= (state == S_GATHER);
      if (rd_pend) begin
        wr_idx <= wr_idx + 1'b1;
        n      <= n + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start && req.query == CMD_QUERY) begin
            cx <= req.cx; cy <= req.cy; cz <= req.cz;
            a <= '0; b <= '0; c <= '0;
            n <= '0; wr_idx <= '0;
            state <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (last_elem) state <= S_LAST;
          else if (c == geom.wz - 3'd1) begin
            c <= '0;
            if (b == geom.wy - 3'd1) begin
              b <= '0;
              a <= a + 3'd1;
            end else b <= b + 3'd1;
          end else c <= c + 3'd1;
        end
        S_LAST: begin
          // last sample lands in the scratch memory this cycle
          cand <= '0;
          scan_phase <= 1'b0;
          cmp_pend <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!scan_phase) begin
            // win_q holds win[cand] in the cycle after the address is set
            if (cmp_pend) begin
              cand_val <= win_q;
              jdx <= '0;
              less_cnt <= '0;
              eq_cnt <= '0;
              scan_phase <= 1'b1;
              cmp_pend <= 1'b0;
            end else cmp_pend <= 1'b1;
          end else begin
            if (jdx < n) jdx <= jdx + 1'b1;
            if (cmp_pend) begin
              if (win_q < cand_val) less_cnt <= less_cnt + 1'b1;
              else if (win_q == cand_val) eq_cnt <= eq_cnt + 1'b1;
            end
            cmp_pend <= (jdx < n);
            if (!cmp_pend && jdx == n) begin
              if (less_cnt <= rank && rank < less_cnt + eq_cnt) begin
                result <= cand_val;
                state  <= S_DONE;
              end else begin
                cand <= cand + 1'b1;
                scan_phase <= 1'b0;
              end
            end
          end
        end
        S_DONE: begin
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_full;
  assign median_value = result;

endmodule

// ===== rtl/core/median_filter_3d_reflect.sv =====
// top level of the 3-d median filter with reflected borders
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  request  | push / full      | command, pos_x, pos_y, pos_z, voxel_value
//  result   | pop / empty      | median_value
//  config   | apb psel/penable | paddr, pwdata, prdata
//
// a write request is stored in the volume memory as the back end takes it; a query
// gathers w = win_x*win_y*win_z samples, lands the last sample in the scratch memory,
// runs a rank search over the scratch memory, paced by its single read port,
// and then posts the result.
// rst is synchronous; the volume memory is not cleared.
// a two-entry request queue lets the front accept while the back is busy,
// and a full result register stalls the back until popped.
module median_filter_3d_reflect import mf3d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic [PosBits-1:0] pos_x,
  input  logic [PosBits-1:0] pos_y,
  input  logic [PosBits-1:0] pos_z,
  input  logic [PixBits-1:0] voxel_value,
  output logic               empty,
  input  logic               pop,
  output logic [PixBits-1:0] median_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DimBits-1:0] dim_x, dim_y, dim_z;
  logic [WinBits-1:0] win_x, win_y, win_z;
  geom_t geom;
  logic  req_valid, req_take;
  req_t  req;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= 6'd32; dim_y <= 6'd32; dim_z <= 6'd32;
      win_x <= 3'd3;  win_y <= 3'd3;  win_z <= 3'd3;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        REG_DIM_X: dim_x <= pwdata[DimBits-1:0];
        REG_DIM_Y: dim_y <= pwdata[DimBits-1:0];
        REG_DIM_Z: dim_z <= pwdata[DimBits-1:0];
        REG_WIN_X: win_x <= pwdata[WinBits-1:0];
        REG_WIN_Y: win_y <= pwdata[WinBits-1:0];
        REG_WIN_Z: win_z <= pwdata[WinBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIM_X: prdata = 32'(dim_x);
      REG_DIM_Y: prdata = 32'(dim_y);
      REG_DIM_Z: prdata = 32'(dim_z);
      REG_WIN_X: prdata = 32'(win_x);
      REG_WIN_Y: prdata = 32'(win_y);
      REG_WIN_Z: prdata = 32'(win_z);
      default:   prdata = '0;
    endcase
  end

  // saturate geometry at use
  function automatic logic [DimBits-1:0] sat_dim(input logic [DimBits-1:0] d);
    if (d < 6'd4) return 6'd4;
    if (d > 6'(DimMax)) return 6'(DimMax);
    return d;
  endfunction

  always_comb begin
    geom.dx = sat_dim(dim_x);
    geom.dy = sat_dim(dim_y);
    geom.dz = sat_dim(dim_z);
    geom.wx = (win_x == 3'd0) ? 3'd1 : win_x;
    geom.wy = (win_y == 3'd0) ? 3'd1 : win_y;
    geom.wz = (win_z == 3'd0) ? 3'd1 : win_z;
  end

  mf3d_front u_front (
    .clk, .rst, .push, .full, .command, .pos_x, .pos_y, .pos_z, .voxel_value,
    .geom, .req_valid, .req, .req_take
  );

  mf3d_back u_back (
    .clk, .rst, .req_valid, .req, .req_take, .geom, .empty, .pop, .median_value
  );

endmodule
